[design/futex_waiter_table_core_defines.svh]
// Assertion macros for the futex waiter table core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FUTEX_WAITER_TABLE_CORE_DEFINES_SVH
`define FUTEX_WAITER_TABLE_CORE_DEFINES_SVH

// check a property every cycle outside reset
`define FWT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fwt assertion failed");

// check that a condition implies another one in the same cycle
`define FWT_ASSERT_IMPLIES(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("fwt assertion failed");

`endif

[design/fwt_pkg.sv]
// Types, codes and sizes for the futex waiter table.
// No dependencies; used by fwt_cell, futex_waiter_table_core and the testbench.
package fwt_pkg;

  localparam int WAITERS = 32;
  localparam int IDX_W   = $clog2(WAITERS);
  localparam int CNT_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_WAKE    = 2'd1,
    REQ_REQUEUE = 2'd2,
    REQ_REMOVE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SHIFT  = 2'd1,
    OP_ROTATE = 2'd2,
    OP_CLOSE  = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_SCAN = 3'b010,
    FSM_DONE = 3'b100
  } fsm_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [7:0]  tid;
    logic        woken;
  } entry_t;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] tid;
  } cell_cmd_t;

endpackage

[design/fwt_if.sv]
// Request and response channel interfaces of the futex waiter table.
// Depends on nothing but plain logic types.
interface fwt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key;
  logic [63:0] key2;
  logic [7:0]  task_id;
  logic [31:0] word_value;
  logic [31:0] expected_value;
  logic        check_value;
  logic [5:0]  wake_count;
  logic [5:0]  move_count;

  modport source (output valid, req_type, key, key2, task_id, word_value,
                  expected_value, check_value, wake_count, move_count,
                  input ready);
  modport sink (input valid, req_type, key, key2, task_id, word_value,
                expected_value, check_value, wake_count, move_count,
                output ready);
endinterface

interface fwt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] woken_task;
  logic [6:0] count;
  logic       was_woken;
  logic       last;

  modport source (output valid, status, woken_task, count, was_woken, last,
                  input ready);
  modport sink (input valid, status, woken_task, count, was_woken, last,
                output ready);
endinterface

[design/futex_waiter_table_core.sv]
// Top level of the futex waiter table: controller, result register, cell chain.
// Depends on fwt_pkg, fwt_if, fwt_cell and futex_waiter_table_core_defines.svh.
//
// Usage: requests enter on req_i (valid/ready), results leave on rsp_o
// (valid/ready). Each result is one item; the final one of a request has
// last set and carries the count or the removed waiter's woken mark.
// Enqueue and remove finish in the accept cycle and give one result that
// appears in the next cycle. Wake and requeue rotate the ring of WAITERS
// cells once through the single head cell, one cell a cycle while the
// receiver keeps up, giving one result per woken task, then a summary.
// A request is taken only while the block is idle and the result register is
// empty or being drained. When the receiver stalls, the result register
// holds and the rotation waits at the cell that has a task to report.
// Reset clears every slot's valid bit and the controller; the table is empty.
`include "futex_waiter_table_core_defines.svh"

module futex_waiter_table_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  fwt_req_if.sink   req_i,
  fwt_rsp_if.source rsp_o
);

  localparam int W = fwt_pkg::WAITERS;

  fwt_pkg::fsm_e      state_q, state_d;
  logic [fwt_pkg::IDX_W-1:0] step_q, step_d;
  logic [fwt_pkg::CNT_W-1:0] woken_q, woken_d, moved_q, moved_d;
  logic [fwt_pkg::CNT_W-1:0] nwake_q, nwake_d, nmove_q, nmove_d;
  logic [63:0] key_q, key_d, key2_q, key2_d;
  logic        rq_q, rq_d, check_q, check_d;

  logic                   out_valid_q, out_valid_d;
  fwt_pkg::status_e       out_status_q, out_status_d;
  logic [7:0]             out_task_q, out_task_d;
  logic [fwt_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  logic                   out_wk_q, out_wk_d;
  logic                   out_last_q, out_last_d;

  fwt_pkg::entry_t   ent [W];
  logic              hit [W];
  logic              wk  [W];
  fwt_pkg::cell_cmd_t cmd;
  fwt_pkg::entry_t   new_ent, tail_in, rot_ent, empty_ent;
  logic [W-1:0]      valid_vec;

  logic out_free, accept, head_match, wake_ok, move_ok, proceed;
  logic [fwt_pkg::CNT_W-1:0] sat_wake, sat_move;
  fwt_pkg::req_type_e req;

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = (state_q == fwt_pkg::FSM_IDLE) && out_free;
  assign accept       = req_i.valid && req_i.ready;
  assign req          = fwt_pkg::req_type_e'(req_i.req_type);

  assign sat_wake = (req_i.wake_count > fwt_pkg::CNT_W'(W)) ? fwt_pkg::CNT_W'(W)
                                                            : req_i.wake_count;
  assign sat_move = (req_i.move_count > fwt_pkg::CNT_W'(W)) ? fwt_pkg::CNT_W'(W)
                                                            : req_i.move_count;

  assign new_ent.valid = 1'b1;
  assign new_ent.key   = req_i.key;
  assign new_ent.tid   = req_i.task_id;
  assign new_ent.woken = 1'b0;

  assign empty_ent = '0;

  assign head_match = ent[0].valid && (ent[0].key == key_q) && !ent[0].woken;
  assign wake_ok    = head_match && (woken_q < nwake_q);
  assign move_ok    = head_match && !wake_ok && rq_q && (moved_q < nmove_q);
  assign proceed    = !wake_ok || out_free;

  always_comb begin
    rot_ent = ent[0];
    if (wake_ok) begin
      rot_ent.woken = 1'b1;
    end else if (move_ok) begin
      rot_ent.key = key2_q;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    fwt_pkg::entry_t left, right;
    logic hit_in, wk_in;
    if (i == 0) begin : g_head
      assign left   = new_ent;
      assign hit_in = 1'b0;
      assign wk_in  = 1'b0;
    end else begin : g_body
      assign left   = ent[i-1];
      assign hit_in = hit[i-1];
      assign wk_in  = wk[i-1];
    end
    if (i == W - 1) begin : g_tail
      assign right = tail_in;
    end else begin : g_mid
      assign right = ent[i+1];
    end
    assign valid_vec[i] = ent[i].valid;

    fwt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .hit_i   (hit_in),
      .wk_i    (wk_in),
      .ent_o   (ent[i]),
      .hit_o   (hit[i]),
      .wk_o    (wk[i])
    );
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    woken_d = woken_q;
    moved_d = moved_q;
    nwake_d = nwake_q;
    nmove_d = nmove_q;
    key_d   = key_q;
    key2_d  = key2_q;
    rq_d    = rq_q;
    check_d = check_q;
    cmd.op  = fwt_pkg::OP_HOLD;
    cmd.tid = req_i.task_id;
    tail_in = empty_ent;

    out_valid_d  = rsp_o.ready ? 1'b0 : out_valid_q;
    out_status_d = out_status_q;
    out_task_d   = out_task_q;
    out_count_d  = out_count_q;
    out_wk_d     = out_wk_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      fwt_pkg::FSM_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_task_d   = '0;
          out_count_d  = '0;
          out_wk_d     = 1'b0;
          out_last_d   = 1'b1;
          out_status_d = fwt_pkg::ST_OK;
          case (req)
            fwt_pkg::REQ_ENQUEUE: begin
              if (req_i.key == '0) begin
                out_status_d = fwt_pkg::ST_BAD_KEY;
              end else if (req_i.word_value != req_i.expected_value) begin
                out_status_d = fwt_pkg::ST_MISMATCH;
              end else if (ent[W-1].valid) begin
                out_status_d = fwt_pkg::ST_FULL;
              end else begin
                cmd.op = fwt_pkg::OP_SHIFT;
              end
            end
            fwt_pkg::REQ_REMOVE: begin
              cmd.op = fwt_pkg::OP_CLOSE;
              if (hit[W-1]) begin
                out_wk_d = wk[W-1];
              end else begin
                out_status_d = fwt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              if (req_i.key == '0 ||
                  (req == fwt_pkg::REQ_REQUEUE && req_i.key2 == '0)) begin
                out_status_d = fwt_pkg::ST_BAD_KEY;
              end else if (req == fwt_pkg::REQ_REQUEUE && req_i.check_value &&
                           req_i.word_value != req_i.expected_value) begin
                out_status_d = fwt_pkg::ST_MISMATCH;
              end else begin
                out_valid_d = rsp_o.ready ? 1'b0 : out_valid_q;
                state_d = fwt_pkg::FSM_SCAN;
                step_d  = '0;
                woken_d = '0;
                moved_d = '0;
                nwake_d = sat_wake;
                nmove_d = sat_move;
                key_d   = req_i.key;
                key2_d  = req_i.key2;
                rq_d    = (req == fwt_pkg::REQ_REQUEUE);
                check_d = req_i.check_value;
              end
            end
          endcase
        end
      end
      fwt_pkg::FSM_SCAN: begin
        tail_in = rot_ent;
        if (proceed) begin
          cmd.op = fwt_pkg::OP_ROTATE;
          if (wake_ok) begin
            woken_d      = woken_q + 1'b1;
            out_valid_d  = 1'b1;
            out_status_d = fwt_pkg::ST_OK;
            out_task_d   = ent[0].tid;
            out_count_d  = '0;
            out_wk_d     = 1'b0;
            out_last_d   = 1'b0;
          end
          if (move_ok) begin
            moved_d = moved_q + 1'b1;
          end
          step_d = step_q + 1'b1;
          if (step_q == fwt_pkg::IDX_W'(W - 1)) begin
            state_d = fwt_pkg::FSM_DONE;
          end
        end
      end
      fwt_pkg::FSM_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = fwt_pkg::ST_OK;
          out_task_d   = '0;
          out_count_d  = fwt_pkg::COUNT_W'(woken_q) +
                         ((rq_q && check_q) ? fwt_pkg::COUNT_W'(moved_q) : '0);
          out_wk_d     = 1'b0;
          out_last_d   = 1'b1;
          state_d      = fwt_pkg::FSM_IDLE;
        end
      end
      default: state_d = fwt_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fwt_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      woken_q     <= '0;
      moved_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      woken_q     <= woken_d;
      moved_q     <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nwake_q      <= nwake_d;
    nmove_q      <= nmove_d;
    key_q        <= key_d;
    key2_q       <= key2_d;
    rq_q         <= rq_d;
    check_q      <= check_d;
    out_status_q <= out_status_d;
    out_task_q   <= out_task_d;
    out_count_q  <= out_count_d;
    out_wk_q     <= out_wk_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.woken_task = out_task_q;
  assign rsp_o.count      = out_count_q;
  assign rsp_o.was_woken  = out_wk_q;
  assign rsp_o.last       = out_last_q;

  `FWT_ASSERT_IMPLIES(a_prefix, state_q == fwt_pkg::FSM_IDLE,
                      (valid_vec & (valid_vec + 1'b1)) == '0)
  `FWT_ASSERT_IMPLIES(a_wake_bound, state_q != fwt_pkg::FSM_IDLE, woken_q <= nwake_q)
  `FWT_ASSERT_IMPLIES(a_no_overwrite, out_valid_q && !rsp_o.ready, !req_i.ready)

endmodule

[design/fwt_cell.sv]
// One waiter slot of the table chain: holds an entry, shifts, rotates or closes it out.
// Depends on fwt_pkg for the entry and command types.
module fwt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fwt_pkg::cell_cmd_t cmd_i,
  input  fwt_pkg::entry_t    left_i,
  input  fwt_pkg::entry_t    right_i,
  input  logic               hit_i,
  input  logic               wk_i,
  output fwt_pkg::entry_t    ent_o,
  output logic               hit_o,
  output logic               wk_o
);

  logic        valid_q, valid_d;
  logic [63:0] key_q, key_d;
  logic [7:0]  tid_q, tid_d;
  logic        woken_q, woken_d;
  logic        mine;
  fwt_pkg::entry_t take;
  logic        load;

  assign mine  = valid_q && (tid_q == cmd_i.tid);
  assign hit_o = hit_i | mine;
  assign wk_o  = hit_i ? wk_i : woken_q;

  assign ent_o.valid = valid_q;
  assign ent_o.key   = key_q;
  assign ent_o.tid   = tid_q;
  assign ent_o.woken = woken_q;

  always_comb begin
    take = right_i;
    load = 1'b0;
    unique case (cmd_i.op)
      fwt_pkg::OP_HOLD:   load = 1'b0;
      fwt_pkg::OP_SHIFT: begin
        take = left_i;
        load = 1'b1;
      end
      fwt_pkg::OP_ROTATE: load = 1'b1;
      fwt_pkg::OP_CLOSE:  load = hit_o;
      default:            load = 1'b0;
    endcase
    valid_d = load ? take.valid : valid_q;
    key_d   = load ? take.key   : key_q;
    tid_d   = load ? take.tid   : tid_q;
    woken_d = load ? take.woken : woken_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    tid_q   <= tid_d;
    woken_q <= woken_d;
  end

endmodule

[tb/fwt_tb_if.sv]
// Run limit constants for the futex waiter table testbench.
// No dependencies; used by futex_waiter_table_core_tb.
package fwt_tb_pkg;
  localparam int TB_LIMIT = 400000;
endpackage

[tb/futex_waiter_table_core_tb.sv]
// Testbench for futex_waiter_table_core: directed table, a remove sweep, then random
// requests, every result checked against a behavioral table predictor.
// Depends on fwt_pkg, fwt_if, fwt_tb_pkg and futex_waiter_table_core.
module futex_waiter_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    fwt_pkg::req_type_e rtype;
    logic [63:0] key;
    logic [63:0] key2;
    logic [7:0]  tid;
    logic [31:0] word;
    logic [31:0] expv;
    logic        chk;
    logic [5:0]  nwake;
    logic [5:0]  nmove;
  } req_t;

  typedef struct packed {
    fwt_pkg::status_e status;
    logic [7:0] woken_task;
    logic [6:0] count;
    logic       was_woken;
    logic       last;
  } rsp_t;

  typedef struct {
    req_t r;
    logic has_exp;
    rsp_t e;
  } row_t;

  logic clk_i, rst_ni;
  fwt_req_if req_if();
  fwt_rsp_if rsp_if();

  futex_waiter_table_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  int          n_used;
  logic [63:0] w_key [fwt_pkg::WAITERS];
  logic [7:0]  w_tid [fwt_pkg::WAITERS];
  logic        w_woken [fwt_pkg::WAITERS];
  rsp_t        pending_rsp[$];
  int          errors;
  int          cycles;
  bit          hold_rsp;
  bit          no_idle;
  bit          stim_done;
  row_t        dir_rows[$];
  logic        dir_chk[$];
  rsp_t        dir_exp[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic rsp_t mk(fwt_pkg::status_e s, logic [7:0] t, logic [6:0] c, logic wk,
                              logic l);
    rsp_t x;
    x.status = s; x.woken_task = t; x.count = c; x.was_woken = wk; x.last = l;
    return x;
  endfunction

  task automatic predict_table(input req_t r);
    int nw, nm, woken, moved, j;
    logic wk;
    bit found;
    nw = (r.nwake > fwt_pkg::WAITERS) ? fwt_pkg::WAITERS : r.nwake;
    nm = (r.nmove > fwt_pkg::WAITERS) ? fwt_pkg::WAITERS : r.nmove;
    woken = 0; moved = 0; found = 0;
    case (r.rtype)
      fwt_pkg::REQ_ENQUEUE: begin
        if (r.key == 0) pending_rsp.push_back(mk(fwt_pkg::ST_BAD_KEY, 0, 0, 0, 1));
        else if (r.word != r.expv) pending_rsp.push_back(mk(fwt_pkg::ST_MISMATCH, 0, 0, 0, 1));
        else if (n_used >= fwt_pkg::WAITERS)
          pending_rsp.push_back(mk(fwt_pkg::ST_FULL, 0, 0, 0, 1));
        else begin
          for (j = n_used; j > 0; j--) begin
            w_key[j] = w_key[j-1]; w_tid[j] = w_tid[j-1]; w_woken[j] = w_woken[j-1];
          end
          w_key[0] = r.key; w_tid[0] = r.tid; w_woken[0] = 0;
          n_used++;
          pending_rsp.push_back(mk(fwt_pkg::ST_OK, 0, 0, 0, 1));
        end
      end
      fwt_pkg::REQ_WAKE, fwt_pkg::REQ_REQUEUE: begin
        if (r.key == 0 || (r.rtype == fwt_pkg::REQ_REQUEUE && r.key2 == 0))
          pending_rsp.push_back(mk(fwt_pkg::ST_BAD_KEY, 0, 0, 0, 1));
        else if (r.rtype == fwt_pkg::REQ_REQUEUE && r.chk && r.word != r.expv)
          pending_rsp.push_back(mk(fwt_pkg::ST_MISMATCH, 0, 0, 0, 1));
        else begin
          for (j = 0; j < n_used; j++) begin
            if (w_key[j] != r.key || w_woken[j]) continue;
            if (woken < nw) begin
              w_woken[j] = 1;
              pending_rsp.push_back(mk(fwt_pkg::ST_OK, w_tid[j], 0, 0, 0));
              woken++;
            end else if (r.rtype == fwt_pkg::REQ_REQUEUE && moved < nm) begin
              w_key[j] = r.key2;
              moved++;
            end else if (r.rtype == fwt_pkg::REQ_WAKE) break;
          end
          pending_rsp.push_back(mk(fwt_pkg::ST_OK, 0,
            7'(woken + ((r.rtype == fwt_pkg::REQ_REQUEUE && r.chk) ? moved : 0)), 0, 1));
        end
      end
      default: begin
        for (j = 0; j < n_used && !found; j++) begin
          if (w_tid[j] == r.tid) begin
            found = 1;
            wk = w_woken[j];
            for (int m = j; m + 1 < n_used; m++) begin
              w_key[m] = w_key[m+1]; w_tid[m] = w_tid[m+1]; w_woken[m] = w_woken[m+1];
            end
            n_used--;
            pending_rsp.push_back(mk(fwt_pkg::ST_OK, 0, 0, wk, 1));
          end
        end
        if (!found) pending_rsp.push_back(mk(fwt_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
      end
    endcase
  endtask

  function automatic req_t mkreq(fwt_pkg::req_type_e t, logic [63:0] k, logic [63:0] k2,
                                 logic [7:0] id, logic [31:0] w, logic [31:0] e,
                                 logic c, logic [5:0] nw, logic [5:0] nm);
    req_t r;
    r.rtype = t; r.key = k; r.key2 = k2; r.tid = id; r.word = w; r.expv = e;
    r.chk = c; r.nwake = nw; r.nmove = nm;
    return r;
  endfunction

  function automatic logic [63:0] rkey();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 64'd0;
    if (sel == 1) return {$urandom, $urandom};
    if (sel == 2) return 64'hFFFF_FFFF_FFFF_FFFF;
    return 64'(sel % 4 + 1) << (($urandom_range(0, 1)) ? 63 - 2 : 0) | 64'h10;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int sel;
    logic [31:0] w;
    w = $urandom;
    sel = $urandom_range(0, 99);
    r.key = rkey();
    r.key2 = rkey();
    r.tid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    r.word = w;
    r.expv = ($urandom_range(0, 9) == 0) ? $urandom : w;
    r.chk = 1'($urandom_range(0, 1));
    r.nwake = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
    r.nmove = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
    if (sel < 45) r.rtype = fwt_pkg::REQ_ENQUEUE;
    else if (sel < 65) r.rtype = fwt_pkg::REQ_WAKE;
    else if (sel < 80) r.rtype = fwt_pkg::REQ_REQUEUE;
    else r.rtype = fwt_pkg::REQ_REMOVE;
    return r;
  endfunction

  task automatic send(input req_t r);
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while (!no_idle && $urandom_range(0, 99) < 36);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= r.rtype;
    req_if.key            <= r.key;
    req_if.key2           <= r.key2;
    req_if.task_id        <= r.tid;
    req_if.word_value     <= r.word;
    req_if.expected_value <= r.expv;
    req_if.check_value    <= r.chk;
    req_if.wake_count     <= r.nwake;
    req_if.move_count     <= r.nmove;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      req_t r;
      r = mkreq(fwt_pkg::req_type_e'(req_if.req_type), req_if.key, req_if.key2,
                req_if.task_id, req_if.word_value, req_if.expected_value,
                req_if.check_value, req_if.wake_count, req_if.move_count);
      predict_table(r);
      if (dir_chk.size() > 0) begin
        if (dir_chk.pop_front()) begin
          rsp_t d;
          d = dir_exp.pop_front();
          if (pending_rsp.size() == 0) begin
            $error("directed row: expected %p, predicted nothing", d);
            errors++;
          end else if (pending_rsp[$] != d) begin
            $error("directed row: expected %p, predicted %p", d, pending_rsp[$]);
            errors++;
          end
        end else void'(dir_exp.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("unexpected item: status %0d task %0d", rsp_if.status, rsp_if.woken_task);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_if.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp_if.status); errors++;
        end
        if (rsp_if.woken_task !== e.woken_task) begin
          $error("woken_task: expected %0d, actual %0d", e.woken_task, rsp_if.woken_task);
          errors++;
        end
        if (rsp_if.count !== e.count) begin
          $error("count: expected %0d, actual %0d", e.count, rsp_if.count); errors++;
        end
        if (rsp_if.was_woken !== e.was_woken) begin
          $error("was_woken: expected %0d, actual %0d", e.was_woken, rsp_if.was_woken);
          errors++;
        end
        if (rsp_if.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, rsp_if.last); errors++;
        end
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 36);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > fwt_tb_pkg::TB_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    hold_rsp = 0;
    wait (stim_done === 1'b0);
    wait (rst_ni);
    repeat (60) @(posedge clk_i);
    hold_rsp = 1;
    repeat (300) @(posedge clk_i);
    hold_rsp = 0;
  end

  initial begin
    int drain;
    errors = 0; n_used = 0; no_idle = 0; stim_done = 0;
    req_if.valid = 0; req_if.req_type = fwt_pkg::REQ_ENQUEUE; req_if.key = 0;
    req_if.key2 = 0; req_if.task_id = 0; req_if.word_value = 0;
    req_if.expected_value = 0; req_if.check_value = 0; req_if.wake_count = 0;
    req_if.move_count = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: errors on empty table, extremes, each operation
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_WAKE, 64'h5, 0, 0, 0, 0, 0, 6'd1, 0), 1,
                         mk(fwt_pkg::ST_OK, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REMOVE, 0, 0, 8'hFF, 0, 0, 0, 0, 0), 1,
                         mk(fwt_pkg::ST_NOT_FOUND, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_ENQUEUE, 0, 0, 1, 0, 0, 0, 0, 0), 1,
                         mk(fwt_pkg::ST_BAD_KEY, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_ENQUEUE, 64'h5, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0), 1,
                         mk(fwt_pkg::ST_MISMATCH, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_WAKE, 0, 0, 0, 0, 0, 0, 6'd1, 0), 1,
                         mk(fwt_pkg::ST_BAD_KEY, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REQUEUE, 64'h5, 0, 0, 0, 0, 0, 1, 1), 1,
                         mk(fwt_pkg::ST_BAD_KEY, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REQUEUE, 64'h5, 64'h6, 0, 1, 2, 1, 1, 1), 1,
                         mk(fwt_pkg::ST_MISMATCH, 0, 0, 0, 1)});
    for (int i = 0; i < 4; i++)
      dir_rows.push_back('{mkreq(fwt_pkg::REQ_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 8'(i * 85),
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0), 1,
                           mk(fwt_pkg::ST_OK, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_ENQUEUE, 64'h5, 0, 8'hFF, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REQUEUE, 64'hFFFF_FFFF_FFFF_FFFF,
                               64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1, 6'd1, 6'd63), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5, 0, 7, 7,
                               0, 6'd1, 6'd63), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_WAKE, 64'h5, 0, 0, 0, 0, 0, 6'd63, 0), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REMOVE, 0, 0, 8'hFF, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_REMOVE, 0, 0, 8'hAA, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_WAKE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0,
                               6'd0, 0), 0, '0});
    for (int i = 0; i < 31; i++)
      dir_rows.push_back('{mkreq(fwt_pkg::REQ_ENQUEUE, 64'h9, 0, 8'(i), 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_ENQUEUE, 64'h9, 0, 8'd77, 0, 0, 0, 0, 0), 1,
                         mk(fwt_pkg::ST_FULL, 0, 0, 0, 1)});
    dir_rows.push_back('{mkreq(fwt_pkg::REQ_WAKE, 64'h9, 0, 0, 0, 0, 0, 6'd32, 0), 0, '0});
    foreach (dir_rows[i]) begin
      dir_chk.push_back(dir_rows[i].has_exp);
      dir_exp.push_back(dir_rows[i].e);
    end
    foreach (dir_rows[i]) send(dir_rows[i].r);
    for (int i = 0; i < 32; i++)
      send(mkreq(fwt_pkg::REQ_REMOVE, 0, 0, ($urandom_range(0, 1)) ? 8'(i) : 8'hFF,
                 0, 0, 0, 0, 0));

    for (int i = 0; i < 128; i++) begin
      no_idle = (i >= 60 && i < 90);
      send(rand_req());
    end
    req_if.valid <= 1'b0;
    no_idle = 0;
    stim_done = 1;
    drain = 0;
    while (pending_rsp.size() > 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (80) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
